// ----- rtl/core/morphing_wavetable_oscillator_top_macros.svh -----
// Assertion macros shared by the oscillator RTL.
`ifndef MORPHING_WAVETABLE_OSCILLATOR_TOP_MACROS_SVH
`define MORPHING_WAVETABLE_OSCILLATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define MWO_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define MWO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/mwo_pkg.sv -----
// Shared types and constants of the morphing wavetable oscillator.
package mwo_pkg;

    // Field widths fixed by the item format
    localparam int FREQ_W     = 24;
    localparam int POS_W      = 19;
    localparam int POS_FRAC   = 16;
    localparam int OUT_W      = 16;
    localparam int SCALE_W    = 31;
    localparam int WCOUNT_W   = 4;
    localparam int PROD_W     = FREQ_W + SCALE_W;
    localparam int INC_SHIFT  = 16;
    localparam int PHASE_FRAC = 21;
    localparam int BASE_LOG2  = 11;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SCALE_W;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_SCALE = 1'd1;
    localparam logic [WCOUNT_W-1:0]  WAVE_COUNT_RST  = 4'd8;
    localparam logic [SCALE_W-1:0]   PHASE_SCALE_RST = 31'd24932236;

    // Item function codes
    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_PROCESS = 1'b1;

    typedef struct packed {
        logic               func;
        logic [2:0]         osc;
        logic [FREQ_W-1:0]  freq_q8;
        logic [POS_W-1:0]   wave_position;
        logic [2:0]         table_wave;
        logic [10:0]        table_addr;
        logic signed [15:0] table_value;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] sample_out;
    } t_out_item;

    // Step strobes for the phase increment unit
    typedef struct packed {
        logic load;
        logic scale;
    } t_inc_ctl;

endpackage

// ----- rtl/core/mwo_chan_if.sv -----
// Valid/ready channel interface carrying one payload per transaction.
interface mwo_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/mwo_incr.sv -----
// Phase increment unit: frequency times scale, range scaling and saturation.
module mwo_incr #(
    parameter int TABLE_LEN = 2048,
    parameter int PW        = 32
) (
    input  logic                          i_clk,
    input  mwo_pkg::t_inc_ctl             i_ctl,
    input  logic [mwo_pkg::FREQ_W-1:0]    i_freq,
    input  logic [mwo_pkg::SCALE_W-1:0]   i_scale,
    output logic [PW-1:0]                 o_inc
);
    import mwo_pkg::*;

    localparam int TLW = $clog2(TABLE_LEN + 1);
    localparam int SCW = 32 + TLW;
    localparam logic [63:0] INC_MAX = (64'(TABLE_LEN) << PHASE_FRAC) - 64'd1;

    logic [PROD_W-1:0] r_prod;
    logic [PW-1:0]     r_inc;
    logic [31:0]       w_inc32;
    logic [SCW-1:0]    w_scaled;
    logic [SCW-1:0]    w_div;

    // Drop 16 fraction bits, saturate to 32 bits, rescale to the table length
    always_comb begin
        if (|r_prod[PROD_W-1:INC_SHIFT+32]) begin
            w_inc32 = 32'hFFFF_FFFF;
        end else begin
            w_inc32 = r_prod[INC_SHIFT+31:INC_SHIFT];
        end
        w_scaled = SCW'(w_inc32) * SCW'(TABLE_LEN);
        w_div    = w_scaled >> BASE_LOG2;
    end

    // Two steps: product, then scaled and saturated increment
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_prod <= PROD_W'(i_freq) * PROD_W'(i_scale);
        end
        if (i_ctl.scale) begin
            if (64'(w_div) > INC_MAX) begin
                r_inc <= PW'(INC_MAX);
            end else begin
                r_inc <= PW'(w_div);
            end
        end
    end

    assign o_inc = r_inc;

endmodule

// ----- rtl/core/morphing_wavetable_oscillator_top.sv -----
// Top level of the morphing wavetable oscillator.
//
// Channel   Dir  Payload                                   Transaction when
// i_in      in   func, osc, freq_q8, wave_position,        i_in.valid & i_in.ready
//                table_wave, table_addr, table_value
// o_out     out  sample_out                                o_out.valid & o_out.ready
// i_cfg_*   in   index, data (wave_count, phase_scale)     i_cfg_we
//
// Table writes leave the block idle; writes may follow back to back.
// A process item runs through phase read, four reads through the single wave memory read
// port, two blend steps on the shared multiplier, the final mix and the output load before
// the next item is taken; an item for an absent oscillator goes straight to output as zero.
// Reset is synchronous; phases read as zero through per-oscillator valid bits, the wave
// memory is undefined until written and has no clearing pass.
// A result not taken holds the block in its output step; no input is taken meanwhile.
module morphing_wavetable_oscillator_top #(
    parameter int OSC_COUNT   = 8,
    parameter int MAX_WAVES   = 8,
    parameter int TABLE_LEN   = 2048,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mwo_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mwo_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    mwo_chan_if.sink                          i_in,
    mwo_chan_if.source                        o_out
);
    import mwo_pkg::*;

    `include "morphing_wavetable_oscillator_top_macros.svh"

    localparam int IW     = $clog2(TABLE_LEN);
    localparam int PW     = IW + PHASE_FRAC;
    localparam int OAW    = (OSC_COUNT > 1) ? $clog2(OSC_COUNT) : 1;
    localparam int WDEPTH = MAX_WAVES * TABLE_LEN;
    localparam int AW     = $clog2(WDEPTH);
    localparam int CNW    = $clog2(MAX_WAVES + 1);
    localparam int SB     = SAMPLE_BITS;
    localparam int LW     = SB + 18;
    localparam int SW     = LW + 18;

    localparam logic [PW:0] PH_MOD = (PW + 1)'(TABLE_LEN) << PHASE_FRAC;
    localparam logic signed [24:0] SMP_MAX = 25'((2 ** (SB - 1)) - 1);
    localparam logic signed [24:0] SMP_MIN = 25'(-(2 ** (SB - 1)));
    localparam logic signed [SW-1:0] OUT_MAX  = SW'(32767);
    localparam logic signed [SW-1:0] OUT_MIN  = SW'(-32768);
    localparam logic signed [SW-1:0] RND_HALF = {{(SW - 32){1'b0}}, 1'b1, 31'b0};

    typedef enum logic [3:0] {
        S_IDLE, S_PH, S_RA, S_RB, S_RC, S_RD, S_HI, S_MIX, S_OUT
    } t_state;

    // Control and configuration
    t_state                  r_state;
    logic                    r_zero;
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_sample;
    logic [WCOUNT_W-1:0]     r_wave_count;
    logic [SCALE_W-1:0]      r_phase_scale;
    logic [OSC_COUNT-1:0]    r_ph_vld;

    // Captured item and datapath
    logic [OAW-1:0]          r_osc;
    logic [FREQ_W-1:0]       r_freq;
    logic [POS_W-1:0]        r_pos;
    logic [PW-1:0]           r_ph;
    logic [IW-1:0]           r_i0;
    logic [IW-1:0]           r_i1;
    logic [15:0]             r_v;
    logic [CNW-1:0]          r_w1;
    logic [CNW-1:0]          r_w2;
    logic [15:0]             r_w;
    logic signed [SB-1:0]    r_a;
    logic signed [SB-1:0]    r_b;
    logic signed [SB-1:0]    r_c;
    logic signed [LW-1:0]    r_lo;
    logic signed [LW-1:0]    r_hi;
    logic signed [SW-1:0]    r_sum;

    // Memories
    logic [PW-1:0]           r_ph_mem [OSC_COUNT];
    logic [PW-1:0]           r_ph_rd;
    logic                    r_ph_rd_vld;
    logic signed [SB-1:0]    r_wave_mem [WDEPTH];
    logic signed [SB-1:0]    r_wm_rd;

    logic                    w_acc;
    logic                    w_proc;
    logic                    w_osc_ok;
    logic                    w_out_free;
    logic                    w_wm_we;
    logic [AW-1:0]           w_wm_waddr;
    logic signed [SB-1:0]    w_wm_wdata;
    logic signed [24:0]      w_tval;
    logic [AW-1:0]           w_wm_raddr;
    logic [CNW-1:0]          w_rd_wave;
    logic [IW-1:0]           w_rd_idx;
    logic                    w_ph_we;
    logic [PW-1:0]           w_ph_cur;
    logic [PW-1:0]           w_ph_next;
    logic [PW:0]             w_ph_sum;
    logic [PW-1:0]           w_inc;
    logic [IW-1:0]           w_i0;
    logic [IW-1:0]           w_i1;
    logic [CNW-1:0]          w_count;
    logic [2:0]              w_pos_wave;
    logic [CNW-1:0]          w_w1;
    logic [CNW-1:0]          w_w2;
    logic [15:0]             w_wt;
    logic signed [SB-1:0]    w_bx;
    logic signed [SB-1:0]    w_by;
    logic signed [SB:0]      w_bdiff;
    logic signed [LW-1:0]    w_blend;
    logic signed [LW:0]      w_mdiff;
    logic signed [SW-1:0]    w_sum;
    logic signed [SW-1:0]    w_shr;
    logic signed [OUT_W-1:0] w_sample;
    t_inc_ctl                w_inc_ctl;

    assign w_acc      = i_in.valid && i_in.ready;
    assign w_proc     = i_in.data.func == FUNC_PROCESS;
    assign w_osc_ok   = 32'(i_in.data.osc) < OSC_COUNT;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = r_state == S_IDLE;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_count  <= WAVE_COUNT_RST;
            r_phase_scale <= PHASE_SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WAVE_COUNT:  r_wave_count  <= i_cfg_data[WCOUNT_W-1:0];
                CFG_PHASE_SCALE: r_phase_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer with the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid  <= 1'b1;
                r_out_sample <= r_zero ? '0 : w_sample;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc && w_proc) begin
                        r_zero  <= !w_osc_ok;
                        r_state <= w_osc_ok ? S_PH : S_OUT;
                    end
                end
                S_PH:  r_state <= S_RA;
                S_RA:  r_state <= S_RB;
                S_RB:  r_state <= S_RC;
                S_RC:  r_state <= S_RD;
                S_RD:  r_state <= S_HI;
                S_HI:  r_state <= S_MIX;
                S_MIX: r_state <= S_OUT;
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.data.sample_out = r_out_sample;

    // Table write: saturate to the stored sample width
    always_comb begin
        w_tval = 25'(i_in.data.table_value);
        if (w_tval > SMP_MAX) begin
            w_wm_wdata = SB'(SMP_MAX);
        end else if (w_tval < SMP_MIN) begin
            w_wm_wdata = SB'(SMP_MIN);
        end else begin
            w_wm_wdata = SB'(w_tval);
        end
    end

    assign w_wm_we    = w_acc && !w_proc
                        && 32'(i_in.data.table_wave) < MAX_WAVES
                        && 32'(i_in.data.table_addr) < TABLE_LEN;
    assign w_wm_waddr = AW'(32'(i_in.data.table_wave) * TABLE_LEN
                            + 32'(i_in.data.table_addr));

    // Four sample reads: a, b, c, d
    always_comb begin
        case (r_state)
            S_RA: begin
                w_rd_wave = r_w1;
                w_rd_idx  = r_i0;
            end
            S_RB: begin
                w_rd_wave = r_w2;
                w_rd_idx  = r_i0;
            end
            S_RC: begin
                w_rd_wave = r_w1;
                w_rd_idx  = r_i1;
            end
            default: begin
                w_rd_wave = r_w2;
                w_rd_idx  = r_i1;
            end
        endcase
    end

    assign w_wm_raddr = AW'(32'(w_rd_wave) * TABLE_LEN + 32'(w_rd_idx));

    // Wave memory
    always_ff @(posedge i_clk) begin
        if (w_wm_we) begin
            r_wave_mem[w_wm_waddr] <= w_wm_wdata;
        end
        r_wm_rd <= r_wave_mem[w_wm_raddr];
    end

    // Phase memory; a phase never written reads as zero
    assign w_ph_we = r_state == S_RC;

    always_ff @(posedge i_clk) begin
        if (w_ph_we) begin
            r_ph_mem[r_osc] <= w_ph_next;
        end
        if (w_acc) begin
            r_ph_rd     <= r_ph_mem[OAW'(i_in.data.osc)];
            r_ph_rd_vld <= r_ph_vld[OAW'(i_in.data.osc)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph_vld <= '0;
        end else if (w_ph_we) begin
            r_ph_vld[r_osc] <= 1'b1;
        end
    end

    assign w_ph_cur = r_ph_rd_vld ? r_ph_rd : '0;

    // Sample indices and sample weight from the phase
    assign w_i0 = w_ph_cur[PW-1:PHASE_FRAC];
    assign w_i1 = (32'(w_i0) + 1 >= TABLE_LEN) ? '0 : w_i0 + IW'(1);

    // Wave pair and morph weight
    assign w_pos_wave = r_pos[POS_W-1:POS_FRAC];

    always_comb begin
        if (r_wave_count == '0) begin
            w_count = CNW'(1);
        end else if (32'(r_wave_count) > MAX_WAVES) begin
            w_count = CNW'(MAX_WAVES);
        end else begin
            w_count = CNW'(r_wave_count);
        end
        if (32'(w_pos_wave) >= 32'(w_count)) begin
            w_w1 = w_count - CNW'(1);
            w_wt = '0;
        end else begin
            w_w1 = CNW'(w_pos_wave);
            w_wt = r_pos[POS_FRAC-1:0];
        end
        w_w2 = w_w1 + CNW'(1);
        if (32'(w_w2) >= 32'(w_count)) begin
            w_w2 = '0;
        end
    end

    // Phase advance
    mwo_incr #(
        .TABLE_LEN (TABLE_LEN),
        .PW        (PW)
    ) u_incr (
        .i_clk   (i_clk),
        .i_ctl   (w_inc_ctl),
        .i_freq  (r_freq),
        .i_scale (r_phase_scale),
        .o_inc   (w_inc)
    );

    assign w_inc_ctl.load  = r_state == S_PH;
    assign w_inc_ctl.scale = r_state == S_RA;

    assign w_ph_sum  = {1'b0, r_ph} + {1'b0, w_inc};
    assign w_ph_next = (w_ph_sum >= PH_MOD) ? PW'(w_ph_sum - PH_MOD) : PW'(w_ph_sum);

    // Shared blend across waves: x * 2^16 + (y - x) * w
    assign w_bx      = (r_state == S_HI) ? r_c : r_a;
    assign w_by      = (r_state == S_HI) ? r_wm_rd : r_b;
    assign w_bdiff   = (SB + 1)'(w_by) - (SB + 1)'(w_bx);
    assign w_blend   = (LW'(w_bx) <<< POS_FRAC)
                       + LW'(w_bdiff) * LW'(signed'({1'b0, r_w}));

    // Blend across samples
    assign w_mdiff   = (LW + 1)'(r_hi) - (LW + 1)'(r_lo);
    assign w_sum     = (SW'(r_lo) <<< 16) + SW'(w_mdiff) * SW'(signed'({1'b0, r_v}));

    // Round half up by 2^32 and saturate
    assign w_shr = (r_sum + RND_HALF) >>> 32;

    always_comb begin
        if (w_shr > OUT_MAX) begin
            w_sample = OUT_W'(OUT_MAX);
        end else if (w_shr < OUT_MIN) begin
            w_sample = OUT_W'(OUT_MIN);
        end else begin
            w_sample = OUT_W'(w_shr);
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_osc  <= OAW'(i_in.data.osc);
            r_freq <= i_in.data.freq_q8;
            r_pos  <= i_in.data.wave_position;
        end
        case (r_state)
            S_PH: begin
                r_ph <= w_ph_cur;
                r_i0 <= w_i0;
                r_i1 <= w_i1;
                r_v  <= w_ph_cur[PHASE_FRAC-1 -: 16];
                r_w1 <= w_w1;
                r_w2 <= w_w2;
                r_w  <= w_wt;
            end
            S_RB: r_a <= r_wm_rd;
            S_RC: r_b <= r_wm_rd;
            S_RD: begin
                r_c  <= r_wm_rd;
                r_lo <= w_blend;
            end
            S_HI:  r_hi  <= w_blend;
            S_MIX: r_sum <= w_sum;
            default: ;
        endcase
    end

    // Checks
    `MWO_ASSERT_NEXT(a_proc_blocks_input, w_acc && w_proc, !i_in.ready, "input taken mid-item")
    `MWO_ASSERT_NEXT(a_write_keeps_ready, w_acc && !w_proc, i_in.ready, "table write stalled")
    `MWO_ASSERT_SAME(a_result_from_out, $rose(r_out_valid), $past(r_state == S_OUT),
                     "result loaded outside output step")

endmodule
